>>> src/ede_pkg.sv
`timescale 1ns / 1ps

package ede_pkg;

   localparam int MAX_LEN   = 64;
   localparam int CHAR_BITS = 8;

   // fixed field widths
   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;
   localparam int DIST_W = 7;

   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int ROW_W  = LEN_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_TARGET = 2'd2,
      CMD_FINISH = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      STAT_OK       = 1'b0,
      STAT_OVERFLOW = 1'b1
   } status_type;

   // control bundle from the sequencer to the row memory
   typedef struct packed {
      logic              clear;
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [ROW_W-1:0]  wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } row_ctl_type;

endpackage

>>> src/ede_if.sv
`timescale 1ns / 1ps

interface ede_req_if;
   import ede_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [BYTE_W-1:0] char_in;

   modport source (output valid, command, char_in, input ready);
   modport sink   (input valid, command, char_in, output ready);
endinterface

interface ede_rsp_if;
   import ede_pkg::*;

   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;
   logic              status;

   modport source (output valid, distance, status, input ready);
   modport sink   (input valid, distance, status, output ready);
endinterface

>>> src/ede_row_mem.sv
`timescale 1ns / 1ps

module ede_row_mem (
   input  logic                      clock,
   input  logic                      reset,
   input  ede_pkg::row_ctl_type      ctl,
   output logic [ede_pkg::ROW_W-1:0] rdata
);
   import ede_pkg::*;

   logic [ROW_W-1:0]   mem [MAX_LEN];
   logic [MAX_LEN-1:0] valid_ff;
   logic [ROW_W-1:0]   rdata_ff;

   // an entry not written since the last restart reads as its column number
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= '0;
      end else if (ctl.we) begin
         valid_ff[ctl.waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      if (ctl.re) begin
         rdata_ff <= valid_ff[ctl.raddr] ? mem[ctl.raddr]
                                         : ROW_W'(ctl.raddr) + ROW_W'(1);
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/ede_cell_unit.sv
`timescale 1ns / 1ps

module ede_cell_unit (
   input  logic [ede_pkg::CHAR_BITS-1:0] src_char,
   input  logic [ede_pkg::CHAR_BITS-1:0] tgt_char,
   input  logic [ede_pkg::ROW_W-1:0]     left,
   input  logic [ede_pkg::ROW_W-1:0]     up,
   input  logic [ede_pkg::ROW_W-1:0]     diag,
   output logic [ede_pkg::ROW_W-1:0]     cell_value
);
   import ede_pkg::*;

   logic [ROW_W-1:0] min_lu;
   logic [ROW_W-1:0] min_all;

   always_comb begin
      min_lu     = (left < up) ? left : up;
      min_all    = (min_lu < diag) ? min_lu : diag;
      cell_value = (src_char == tgt_char) ? diag : min_all + ROW_W'(1);
   end

endmodule

>>> src/edit_distance_engine.sv
`timescale 1ns / 1ps

// channel  dir  handshake      payload
// req      in   valid/ready    command[1:0], char_in[7:0]
// rsp      out  valid/ready    distance[6:0], status
//
// Clear and append leave the engine idle; a source byte beyond the limit sets overflow.
// A target byte updates the row one cell per cycle through a single compare/min unit,
// one row read and one row write a cycle.
// Finish reads the row, then registers the result; it waits only while
// an earlier result is still held. Reset is synchronous; no clearing pass is run.
// A held result does not block further requests apart from a later finish.

module edit_distance_engine (
   input logic   clock,
   input logic   reset,
   ede_req_if.sink   req,
   ede_rsp_if.source rsp
);
   import ede_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_RUN    = 3'b010,
      S_REPORT = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [LEN_W-1:0]     src_len_ff, src_len_in;
   logic [LEN_W-1:0]     tgt_len_ff, tgt_len_in;
   logic                 overflow_ff, overflow_in;
   logic [ADDR_W-1:0]    idx_ff, idx_in;
   logic [ROW_W-1:0]     diag_ff, diag_in;
   logic [ROW_W-1:0]     left_ff, left_in;
   logic [CHAR_BITS-1:0] char_ff, char_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]    rsp_dist_ff, rsp_dist_in;
   logic                 rsp_stat_ff, rsp_stat_in;

   logic [CHAR_BITS-1:0] src_mem [MAX_LEN];
   logic [CHAR_BITS-1:0] src_rd_ff;
   logic                 src_we;
   logic                 src_re;
   logic [ADDR_W-1:0]    src_raddr;

   row_ctl_type          row_ctl;
   logic [ROW_W-1:0]     row_rdata;
   logic [ROW_W-1:0]     cell_value;
   logic                 accept;
   logic                 last_cell;
   logic [CHAR_BITS-1:0] req_char;

   ede_row_mem u_row (
      .clock (clock),
      .reset (reset),
      .ctl   (row_ctl),
      .rdata (row_rdata)
   );

   ede_cell_unit u_cell (
      .src_char   (src_rd_ff),
      .tgt_char   (char_ff),
      .left       (left_ff),
      .up         (row_rdata),
      .diag       (diag_ff),
      .cell_value (cell_value)
   );

   always_ff @(posedge clock) begin
      if (src_we) begin
         src_mem[src_len_ff[ADDR_W-1:0]] <= req_char;
      end
      if (src_re) begin
         src_rd_ff <= src_mem[src_raddr];
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign req_char  = req.char_in[CHAR_BITS-1:0];
   assign last_cell = (LEN_W'(idx_ff) + LEN_W'(1) == src_len_ff);

   always_comb begin
      state_in     = state_ff;
      src_len_in   = src_len_ff;
      tgt_len_in   = tgt_len_ff;
      overflow_in  = overflow_ff;
      idx_in       = idx_ff;
      diag_in      = diag_ff;
      left_in      = left_ff;
      char_in      = char_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_stat_in  = rsp_stat_ff;
      src_we       = 1'b0;
      src_re       = 1'b0;
      src_raddr    = '0;
      row_ctl      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (cmd_type'(req.command))
                  CMD_CLEAR: begin
                     src_len_in    = '0;
                     overflow_in   = 1'b0;
                     tgt_len_in    = '0;
                     row_ctl.clear = 1'b1;
                  end
                  CMD_APPEND: begin
                     if (src_len_ff < LEN_W'(MAX_LEN)) begin
                        src_we     = 1'b1;
                        src_len_in = src_len_ff + LEN_W'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                     tgt_len_in    = '0;
                     row_ctl.clear = 1'b1;
                  end
                  CMD_TARGET: begin
                     if (tgt_len_ff == LEN_W'(MAX_LEN)) begin
                        overflow_in = 1'b1;
                     end else begin
                        tgt_len_in = tgt_len_ff + LEN_W'(1);
                        // column zero of the row always equals the target count
                        if (src_len_ff != '0) begin
                           state_in    = S_RUN;
                           idx_in      = '0;
                           diag_in     = ROW_W'(tgt_len_ff);
                           left_in     = ROW_W'(tgt_len_ff) + ROW_W'(1);
                           char_in     = req_char;
                           row_ctl.re  = 1'b1;
                           src_re      = 1'b1;
                        end
                     end
                  end
                  CMD_FINISH: begin
                     state_in      = S_REPORT;
                     row_ctl.re    = 1'b1;
                     row_ctl.raddr = ADDR_W'(src_len_ff - LEN_W'(1));
                  end
                  default: ;
               endcase
            end
         end
         S_RUN: begin
            row_ctl.we    = 1'b1;
            row_ctl.waddr = idx_ff;
            row_ctl.wdata = cell_value;
            left_in       = cell_value;
            diag_in       = row_rdata;
            if (last_cell) begin
               state_in = S_IDLE;
            end else begin
               idx_in        = idx_ff + ADDR_W'(1);
               row_ctl.re    = 1'b1;
               row_ctl.raddr = idx_ff + ADDR_W'(1);
               src_re        = 1'b1;
               src_raddr     = idx_ff + ADDR_W'(1);
            end
         end
         S_REPORT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               if (overflow_ff) begin
                  rsp_dist_in = '0;
                  rsp_stat_in = STAT_OVERFLOW;
               end else begin
                  rsp_dist_in = (src_len_ff == '0) ? DIST_W'(tgt_len_ff)
                                                   : DIST_W'(row_rdata);
                  rsp_stat_in = STAT_OK;
               end
               overflow_in   = 1'b0;
               tgt_len_in    = '0;
               row_ctl.clear = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         src_len_ff   <= '0;
         tgt_len_ff   <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_len_ff   <= src_len_in;
         tgt_len_ff   <= tgt_len_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      diag_ff     <= diag_in;
      left_ff     <= left_in;
      char_ff     <= char_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.distance = rsp_dist_ff;
   assign rsp.status   = rsp_stat_ff;

   a_run_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RUN |-> LEN_W'(idx_ff) < src_len_ff)
      else $error("cell index past source length");

   a_lengths_bounded: assert property (@(posedge clock) disable iff (reset)
      src_len_ff <= LEN_W'(MAX_LEN) && tgt_len_ff <= LEN_W'(MAX_LEN))
      else $error("string length beyond limit");

   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stat_ff |-> rsp_dist_ff == '0)
      else $error("overflow result carries a distance");

   a_report_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REPORT && state_in == S_IDLE |=> !overflow_ff && tgt_len_ff == '0)
      else $error("finish did not restart the comparison");

endmodule

>>> tb/ede_checker.sv
`timescale 1ns / 1ps

module ede_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [ede_pkg::CMD_W-1:0]  req_command,
   input  logic [ede_pkg::BYTE_W-1:0] req_char_in,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [ede_pkg::DIST_W-1:0] rsp_distance,
   input  logic                       rsp_status,
   output int                         mismatch_count,
   output int                         outstanding_results
);
   import ede_pkg::*;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      status_type        status;
   } distance_result_type;

   localparam logic [BYTE_W-1:0] CHAR_MASK = BYTE_W'((1 << CHAR_BITS) - 1);

   distance_result_type expected_distances[$];

   logic [BYTE_W-1:0] source_chars [MAX_LEN];
   int                source_count;
   int                distance_row [MAX_LEN+1];
   int                target_count;
   logic              overflow_seen;

   task automatic report_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic void restart_distance_row();
      for (int i = 0; i <= MAX_LEN; i++) distance_row[i] = i;
      target_count = 0;
   endfunction

   // one target byte: sweep the row, diag holds the old value of the cell to the left
   function automatic void update_distance_row(logic [BYTE_W-1:0] ch);
      int diag, up, best;
      diag = distance_row[0];
      distance_row[0] = diag + 1;
      for (int i = 1; i <= source_count; i++) begin
         up = distance_row[i];
         if (source_chars[i-1] == ch) begin
            distance_row[i] = diag;
         end else begin
            best = distance_row[i-1];
            if (up < best) best = up;
            if (diag < best) best = diag;
            distance_row[i] = best + 1;
         end
         diag = up;
      end
   endfunction

   function automatic void predict_request(cmd_type cmd, logic [BYTE_W-1:0] raw_char);
      logic [BYTE_W-1:0]   ch;
      distance_result_type res;
      ch = raw_char & CHAR_MASK;
      unique case (cmd)
         CMD_CLEAR: begin
            source_count = 0;
            overflow_seen = 1'b0;
            restart_distance_row();
         end
         CMD_APPEND: begin
            if (source_count < MAX_LEN) begin
               source_chars[source_count] = ch;
               source_count++;
            end else begin
               overflow_seen = 1'b1;
            end
            restart_distance_row();
         end
         CMD_TARGET: begin
            if (target_count < MAX_LEN) begin
               update_distance_row(ch);
               target_count++;
            end else begin
               overflow_seen = 1'b1;
            end
         end
         default: begin
            res.distance = overflow_seen ? '0 : DIST_W'(distance_row[source_count]);
            res.status   = overflow_seen ? STAT_OVERFLOW : STAT_OK;
            expected_distances.push_back(res);
            overflow_seen = 1'b0;
            restart_distance_row();
         end
      endcase
   endfunction

   initial begin
      mismatch_count = 0;
      source_count = 0;
      overflow_seen = 1'b0;
      restart_distance_row();
      for (int i = 0; i < MAX_LEN; i++) source_chars[i] = '0;
   end

   assign outstanding_results = expected_distances.size();

   always @(posedge clock) begin
      distance_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_distances.size() == 0) begin
               report_mismatch($sformatf("unexpected result distance=%0d status=%0d",
                                         rsp_distance, rsp_status));
            end else begin
               want = expected_distances.pop_front();
               if (rsp_distance !== want.distance)
                  report_mismatch($sformatf("distance %0d, expected %0d",
                                            rsp_distance, want.distance));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
            end
         end
         if (req_valid && req_ready)
            predict_request(cmd_type'(req_command), req_char_in);
      end
   end

endmodule

>>> tb/tb_edit_distance_engine.sv
`timescale 1ns / 1ps

module tb_edit_distance_engine;
   import ede_pkg::*;

   localparam int RANDOM_REQUESTS = 1800;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   outstanding_results;
   int   sent_count;
   int   req_quiet;
   int   rsp_quiet;

   logic [BYTE_W-1:0] alphabet [4];

   ede_req_if req_ch ();
   ede_rsp_if rsp_ch ();

   edit_distance_engine i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   ede_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_ch.valid),
      .req_ready           (req_ch.ready),
      .req_command         (req_ch.command),
      .req_char_in         (req_ch.char_in),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_distance        (rsp_ch.distance),
      .rsp_status          (rsp_ch.status),
      .mismatch_count      (mismatch_count),
      .outstanding_results (outstanding_results)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #15ms;
      $display("edit_distance_engine regression: fail");
      $finish;
   end

   // random gap before each request, with occasional stretches of back-to-back traffic
   task automatic send_request(cmd_type cmd, logic [BYTE_W-1:0] ch);
      int gap;
      if (req_quiet > 0) begin
         gap = 0;
         req_quiet--;
      end else begin
         gap = $urandom_range(0, 6);
         if ($urandom_range(0, 39) == 0) req_quiet = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.char_in <= ch;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
   endtask

   function automatic logic [BYTE_W-1:0] pick_char();
      if ($urandom_range(0, 6) == 0) return BYTE_W'($urandom_range(0, 255));
      return alphabet[$urandom_range(0, 3)];
   endfunction

   function automatic int pick_length();
      case ($urandom_range(0, 19))
         0:       return $urandom_range(60, 68);
         1:       return 0;
         default: return $urandom_range(1, 10);
      endcase
   endfunction

   // well-formed job: optional clear, source bytes, then one or more target/finish rounds
   task automatic run_comparison();
      int n;
      int rounds;
      for (int i = 0; i < 4; i++) alphabet[i] = BYTE_W'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 0) send_request(CMD_CLEAR, BYTE_W'($urandom_range(0, 255)));
      n = pick_length();
      repeat (n) send_request(CMD_APPEND, pick_char());
      rounds = $urandom_range(1, 3);
      repeat (rounds) begin
         n = pick_length();
         repeat (n) send_request(CMD_TARGET, pick_char());
         send_request(CMD_FINISH, BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   task automatic run_noise();
      int n;
      n = $urandom_range(1, 8);
      repeat (n) send_request(cmd_type'($urandom_range(0, 3)), pick_char());
   endtask

   // response side: random stall before accepting each result
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      rsp_quiet = 0;
      @(posedge clock iff !reset);
      forever begin
         if (rsp_quiet > 0) begin
            stall = 0;
            rsp_quiet--;
         end else begin
            stall = $urandom_range(0, 6);
            if ($urandom_range(0, 19) == 0) rsp_quiet = $urandom_range(5, 20);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.command = CMD_CLEAR;
      req_ch.char_in = '0;
      sent_count     = 0;
      req_quiet      = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty strings, extreme bytes, target with no source, clear mid-compare
      send_request(CMD_FINISH, 8'h00);
      send_request(CMD_TARGET, 8'hFF);
      send_request(CMD_TARGET, 8'h00);
      send_request(CMD_FINISH, 8'hFF);
      send_request(CMD_APPEND, 8'h00);
      send_request(CMD_APPEND, 8'hFF);
      send_request(CMD_APPEND, 8'hAA);
      send_request(CMD_FINISH, 8'h00);
      send_request(CMD_TARGET, 8'hFF);
      send_request(CMD_TARGET, 8'h00);
      send_request(CMD_TARGET, 8'h55);
      send_request(CMD_FINISH, 8'h00);
      send_request(CMD_TARGET, 8'h00);
      send_request(CMD_TARGET, 8'hFF);
      send_request(CMD_TARGET, 8'hAA);
      send_request(CMD_FINISH, 8'h00);
      send_request(CMD_TARGET, 8'hAA);
      send_request(CMD_APPEND, 8'h01);
      send_request(CMD_TARGET, 8'h01);
      send_request(CMD_FINISH, 8'h00);
      send_request(CMD_TARGET, 8'h7F);
      send_request(CMD_CLEAR, 8'hFF);
      send_request(CMD_FINISH, 8'h00);

      while (sent_count < RANDOM_REQUESTS) begin
         if ($urandom_range(0, 4) == 0) run_noise();
         else run_comparison();
      end
      req_ch.valid <= 1'b0;

      while (outstanding_results != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("edit_distance_engine regression: pass");
      end else begin
         $display("edit_distance_engine regression: fail");
      end
      $finish;
   end

endmodule
